// ===== rtl/rgm_pkg.sv =====
// Package for the regularized Gram matrix block.
// Holds sizes, the lower-triangle entry order and the structs passed between stages.
// No dependencies.
package rgm_pkg;

  localparam int RowCount   = 4;
  localparam int NumCols    = 4;
  localparam int NumEntries = 10;
  localparam int SampW      = 16;
  localparam int ProdW      = 2 * SampW + 1;
  localparam int AccW       = 35;
  localparam int CntW       = 6;
  localparam int IdxW       = $clog2(NumEntries);
  localparam int NoiseW     = 32;
  localparam int ColW       = $clog2(NumCols);

  localparam logic [CntW-1:0] LastRow   = CntW'(RowCount - 1);
  localparam logic [IdxW-1:0] LastEntry = IdxW'(NumEntries - 1);

  typedef logic signed [SampW-1:0] samp_t;
  typedef logic [AccW-1:0] acc_t;

  typedef struct packed {
    logic                             valid;
    logic                             last;
    logic [NumEntries-1:0][ProdW-1:0] re;
    logic [NumEntries-1:0][ProdW-1:0] im;
  } prod_bus_t;

  typedef struct packed {
    logic            valid;
    logic [IdxW-1:0] idx;
    acc_t            re;
    acc_t            im;
  } head_t;

  // column-major lower triangle: (0,0) (1,0) (2,0) (3,0) (1,1) (2,1) (3,1) (2,2) (3,2) (3,3)
  function automatic logic [ColW-1:0] ent_row(input logic [IdxW-1:0] idx);
    logic [ColW-1:0] r;
    case (idx) inside
      4'd0:             r = 2'd0;
      4'd1, 4'd4:       r = 2'd1;
      4'd2, 4'd5, 4'd7: r = 2'd2;
      4'd3, 4'd6, 4'd8,
      4'd9:             r = 2'd3;
      default:          r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [ColW-1:0] ent_col(input logic [IdxW-1:0] idx);
    logic [ColW-1:0] c;
    case (idx) inside
      4'd0, 4'd1, 4'd2, 4'd3: c = 2'd0;
      4'd4, 4'd5, 4'd6:       c = 2'd1;
      4'd7, 4'd8:             c = 2'd2;
      4'd9:                   c = 2'd3;
      default:                c = 2'd0;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/rgm_if.sv =====
// Channel interfaces of the regularized Gram matrix block: row requests in, entries out.
// Depends on rgm_pkg.
interface rgm_in_if
  import rgm_pkg::*;
;
  logic  valid;
  logic  ready;
  samp_t h0_re;
  samp_t h0_im;
  samp_t h1_re;
  samp_t h1_im;
  samp_t h2_re;
  samp_t h2_im;
  samp_t h3_re;
  samp_t h3_im;

  modport source (output valid, h0_re, h0_im, h1_re, h1_im, h2_re, h2_im, h3_re, h3_im,
                  input ready);
  modport sink   (input valid, h0_re, h0_im, h1_re, h1_im, h2_re, h2_im, h3_re, h3_im,
                  output ready);
endinterface

interface rgm_out_if
  import rgm_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic [ColW-1:0]        entry_row;
  logic [ColW-1:0]        entry_col;
  logic signed [AccW-1:0] gram_re;
  logic signed [AccW-1:0] gram_im;
  logic                   final_entry;

  modport source (output valid, entry_row, entry_col, gram_re, gram_im, final_entry,
                  input ready);
  modport sink   (input valid, entry_row, entry_col, gram_re, gram_im, final_entry,
                  output ready);
endinterface

// ===== rtl/rgm_mult.sv =====
// Input register, row counter and the ten conjugate-product lanes.
// Depends on rgm_pkg and rgm_in_if.
module rgm_mult
  import rgm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  rgm_in_if.sink    in_i,
  input  logic      hold_i,
  output prod_bus_t prod_o
);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            s1_v_q, s1_last_q;
  logic            s2_v_q, s2_last_q;
  samp_t           in_hr [NumCols];
  samp_t           in_hi [NumCols];
  samp_t           s1_hr_q [NumCols];
  samp_t           s1_hi_q [NumCols];
  logic signed [2*SampW-1:0] p_rr [NumEntries];
  logic signed [2*SampW-1:0] p_ii [NumEntries];
  logic signed [2*SampW-1:0] p_ri [NumEntries];
  logic signed [2*SampW-1:0] p_ir [NumEntries];
  logic [NumEntries-1:0][ProdW-1:0] re_d, im_d;
  logic [NumEntries-1:0][ProdW-1:0] re_q, im_q;
  logic in_last;

  assign in_i.ready = !hold_i;
  assign in_last    = (cnt_q == LastRow);
  assign cnt_d      = in_last ? '0 : cnt_q + 1'b1;

  always_comb begin
    in_hr[0] = in_i.h0_re;
    in_hi[0] = in_i.h0_im;
    in_hr[1] = in_i.h1_re;
    in_hi[1] = in_i.h1_im;
    in_hr[2] = in_i.h2_re;
    in_hi[2] = in_i.h2_im;
    in_hr[3] = in_i.h3_re;
    in_hi[3] = in_i.h3_im;
  end

  // conj(x) * y with x = column i, y = column j
  always_comb begin
    for (int e = 0; e < NumEntries; e++) begin
      p_rr[e] = s1_hr_q[ent_row(IdxW'(e))] * s1_hr_q[ent_col(IdxW'(e))];
      p_ii[e] = s1_hi_q[ent_row(IdxW'(e))] * s1_hi_q[ent_col(IdxW'(e))];
      p_ri[e] = s1_hr_q[ent_row(IdxW'(e))] * s1_hi_q[ent_col(IdxW'(e))];
      p_ir[e] = s1_hi_q[ent_row(IdxW'(e))] * s1_hr_q[ent_col(IdxW'(e))];
      re_d[e] = ProdW'(p_rr[e]) + ProdW'(p_ii[e]);
      im_d[e] = ProdW'(p_ri[e]) - ProdW'(p_ir[e]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else if (!hold_i) begin
      s1_v_q <= in_i.valid;
      s2_v_q <= s1_v_q;
      if (in_i.valid) begin
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!hold_i) begin
      if (in_i.valid) begin
        s1_hr_q   <= in_hr;
        s1_hi_q   <= in_hi;
        s1_last_q <= in_last;
      end
      re_q      <= re_d;
      im_q      <= im_d;
      s2_last_q <= s1_last_q;
    end
  end

  assign prod_o.valid = s2_v_q;
  assign prod_o.last  = s2_last_q;
  assign prod_o.re    = re_q;
  assign prod_o.im    = im_q;

endmodule

// ===== rtl/rgm_accum.sv =====
// Ten complex accumulators and the result bank that holds a finished matrix.
// Depends on rgm_pkg.
module rgm_accum
  import rgm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  prod_bus_t prod_i,
  input  logic      pop_i,
  output logic      hold_o,
  output head_t     head_o
);

  acc_t            acc_re_q  [NumEntries];
  acc_t            acc_im_q  [NumEntries];
  acc_t            sum_re    [NumEntries];
  acc_t            sum_im    [NumEntries];
  acc_t            bank_re_q [NumEntries];
  acc_t            bank_im_q [NumEntries];
  logic            full_q;
  logic [IdxW-1:0] idx_q;
  logic            take;

  assign hold_o = prod_i.valid & prod_i.last & full_q;
  assign take   = prod_i.valid & !hold_o;

  always_comb begin
    for (int e = 0; e < NumEntries; e++) begin
      sum_re[e] = acc_re_q[e] + {{(AccW-ProdW){prod_i.re[e][ProdW-1]}}, prod_i.re[e]};
      sum_im[e] = acc_im_q[e] + {{(AccW-ProdW){prod_i.im[e][ProdW-1]}}, prod_i.im[e]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
      idx_q  <= '0;
      for (int e = 0; e < NumEntries; e++) begin
        acc_re_q[e] <= '0;
        acc_im_q[e] <= '0;
      end
    end else begin
      if (take) begin
        for (int e = 0; e < NumEntries; e++) begin
          acc_re_q[e] <= prod_i.last ? '0 : sum_re[e];
          acc_im_q[e] <= prod_i.last ? '0 : sum_im[e];
        end
      end
      if (take && prod_i.last) begin
        full_q <= 1'b1;
      end else if (pop_i && idx_q == LastEntry) begin
        full_q <= 1'b0;
      end
      if (pop_i) begin
        idx_q <= (idx_q == LastEntry) ? '0 : idx_q + 1'b1;
      end
    end
  end

  // bank shifts toward slot 0 as entries leave
  always_ff @(posedge clk_i) begin
    if (take && prod_i.last) begin
      bank_re_q <= sum_re;
      bank_im_q <= sum_im;
    end else if (pop_i) begin
      for (int e = 0; e < NumEntries - 1; e++) begin
        bank_re_q[e] <= bank_re_q[e+1];
        bank_im_q[e] <= bank_im_q[e+1];
      end
    end
  end

  assign head_o.valid = full_q;
  assign head_o.idx   = idx_q;
  assign head_o.re    = bank_re_q[0];
  assign head_o.im    = bank_im_q[0];

endmodule

// ===== rtl/rgm_emit.sv =====
// Result register: adds the noise variance on diagonal entries and tags row, column, last.
// Depends on rgm_pkg and rgm_out_if; holds the noise_variance register.
module rgm_emit
  import rgm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [NoiseW-1:0] cfg_wdata_i,
  input  head_t             head_i,
  output logic              pop_o,
  rgm_out_if.source         res_o
);

  logic [NoiseW-1:0] noise_q;
  logic              valid_q;
  logic [ColW-1:0]   row_q, col_q;
  acc_t              re_q, im_q;
  logic              final_q;
  logic [ColW-1:0]   row_d, col_d;
  acc_t              re_d;

  assign pop_o = head_i.valid & (!valid_q | res_o.ready);
  assign row_d = ent_row(head_i.idx);
  assign col_d = ent_col(head_i.idx);
  assign re_d  = head_i.re + ((row_d == col_d) ? AccW'(noise_q) : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_q <= '0;
      valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        noise_q <= cfg_wdata_i;
      end
      if (pop_o) begin
        valid_q <= 1'b1;
      end else if (res_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      row_q   <= row_d;
      col_q   <= col_d;
      re_q    <= re_d;
      im_q    <= head_i.im;
      final_q <= (head_i.idx == LastEntry);
    end
  end

  assign res_o.valid       = valid_q;
  assign res_o.entry_row   = row_q;
  assign res_o.entry_col   = col_q;
  assign res_o.gram_re     = re_q;
  assign res_o.gram_im     = im_q;
  assign res_o.final_entry = final_q;

endmodule

// ===== rtl/regularized_gram_matrix.sv =====
// Top level of the regularized Gram matrix block (G = H^H*H + sigma^2*I, lower triangle).
// Depends on rgm_pkg, rgm_if, rgm_mult, rgm_accum and rgm_emit.
//
//   channel   dir  handshake          payload
//   in_i      in   valid/ready        h0..h3 re/im, Q1.15
//   res_o     out  valid/ready        entry_row, entry_col, gram_re, gram_im, final_entry
//   cfg       in   cfg_we_i           cfg_wdata_i -> noise_variance
//
// One row request is taken per cycle while the input is not held; a row passes the
// input and product registers before it reaches the accumulators. Every RowCount rows
// the matrix moves into a bank and drains one entry per cycle while the output is ready;
// the bank reloads the cycle after its last entry leaves, so output sets the sustained rate.
// Input stalls only while a finished matrix waits for the bank to empty.
// Reset clears accumulators, row count and noise_variance; no clearing pass.
module regularized_gram_matrix
  import rgm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  rgm_in_if.sink            in_i,
  rgm_out_if.source         res_o,
  input  logic              cfg_we_i,
  input  logic [NoiseW-1:0] cfg_wdata_i
);

  prod_bus_t prod;
  head_t     head;
  logic      hold;
  logic      pop;

  rgm_mult u_mult (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .hold_i (hold),
    .prod_o (prod)
  );

  rgm_accum u_accum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .prod_i (prod),
    .pop_i  (pop),
    .hold_o (hold),
    .head_o (head)
  );

  rgm_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .head_i      (head),
    .pop_o       (pop),
    .res_o       (res_o)
  );

endmodule

// ===== rtl/rgm_checker.sv =====
// Port-level checks for the regularized Gram matrix block, bound to the top level.
// Depends on rgm_pkg.
module rgm_checker
  import rgm_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic [ColW-1:0]        entry_row_i,
  input logic [ColW-1:0]        entry_col_i,
  input logic signed [AccW-1:0] gram_re_i,
  input logic signed [AccW-1:0] gram_im_i,
  input logic                   final_entry_i
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(gram_re_i) && $stable(gram_im_i)
                                    && $stable(entry_row_i) && $stable(entry_col_i))
    else $error("stalled result changed");

  a_lower: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> entry_col_i <= entry_row_i)
    else $error("entry above diagonal");

  a_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && final_entry_i |-> entry_row_i == 2'd3 && entry_col_i == 2'd3)
    else $error("final entry is not (3,3)");

  a_diag_im: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && entry_row_i == entry_col_i |-> gram_im_i == '0)
    else $error("diagonal imaginary part not zero");

endmodule

bind regularized_gram_matrix rgm_checker u_rgm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (res_o.valid),
  .out_ready_i   (res_o.ready),
  .entry_row_i   (res_o.entry_row),
  .entry_col_i   (res_o.entry_col),
  .gram_re_i     (res_o.gram_re),
  .gram_im_i     (res_o.gram_im),
  .final_entry_i (res_o.final_entry)
);

// ===== test/gram_check_pkg.sv =====
`timescale 1ns / 100ps
// Gram matrix checker: row and entry types plus a scoreboard class that predicts
// the ten lower-triangle entries per matrix and compares them with the DUT output.
// Depends on rgm_pkg.
package gram_check_pkg;
  import rgm_pkg::*;

  typedef struct {
    samp_t re[NumCols];
    samp_t im[NumCols];
  } h_row_t;

  typedef struct packed {
    logic [ColW-1:0]        entry_row;
    logic [ColW-1:0]        entry_col;
    logic signed [AccW-1:0] gram_re;
    logic signed [AccW-1:0] gram_im;
    logic                   final_entry;
  } gram_entry_t;

  class gram_scoreboard;
    acc_t              sum_re[NumEntries];
    acc_t              sum_im[NumEntries];
    int unsigned       rows_acc;
    logic [NoiseW-1:0] noise;
    gram_entry_t       gram_q[$];
    int unsigned       errors;
    int unsigned       rows_noted;
    int unsigned       entries_checked;

    function new();
      for (int e = 0; e < NumEntries; e++) begin
        sum_re[e] = '0;
        sum_im[e] = '0;
      end
      rows_acc        = 0;
      noise           = '0;
      errors          = 0;
      rows_noted      = 0;
      entries_checked = 0;
    endfunction

    function void set_noise(logic [NoiseW-1:0] v);
      noise = v;
    endfunction

    function int pending();
      return gram_q.size();
    endfunction

    // accumulate conj(x_i) * x_j, emit the matrix on its last row
    function void note_row(h_row_t r);
      int          e;
      longint      pr;
      longint      pi;
      acc_t        re;
      gram_entry_t ent;
      e = 0;
      for (int j = 0; j < NumCols; j++) begin
        for (int i = j; i < NumCols; i++) begin
          pr = longint'(r.re[i]) * longint'(r.re[j]) + longint'(r.im[i]) * longint'(r.im[j]);
          pi = longint'(r.re[i]) * longint'(r.im[j]) - longint'(r.im[i]) * longint'(r.re[j]);
          sum_re[e] = sum_re[e] + acc_t'(pr);
          sum_im[e] = sum_im[e] + acc_t'(pi);
          e++;
        end
      end
      rows_noted++;
      rows_acc++;
      if (rows_acc == RowCount) begin
        e = 0;
        for (int j = 0; j < NumCols; j++) begin
          for (int i = j; i < NumCols; i++) begin
            re = sum_re[e];
            if (i == j) begin
              re = re + acc_t'(noise);
            end
            ent.entry_row   = ColW'(i);
            ent.entry_col   = ColW'(j);
            ent.gram_re     = re;
            ent.gram_im     = sum_im[e];
            ent.final_entry = (e == NumEntries - 1);
            gram_q.push_back(ent);
            sum_re[e] = '0;
            sum_im[e] = '0;
            e++;
          end
        end
        rows_acc = 0;
      end
    endfunction

    function void check_entry(gram_entry_t got);
      gram_entry_t want;
      entries_checked++;
      if (gram_q.size() == 0) begin
        $error("unexpected Gram entry row %0d col %0d", got.entry_row, got.entry_col);
        errors++;
        return;
      end
      want = gram_q.pop_front();
      if (got.entry_row !== want.entry_row) begin
        $error("entry_row: expected %0d, got %0d", want.entry_row, got.entry_row);
        errors++;
      end
      if (got.entry_col !== want.entry_col) begin
        $error("entry_col: expected %0d, got %0d", want.entry_col, got.entry_col);
        errors++;
      end
      if (got.gram_re !== want.gram_re) begin
        $error("gram_re: expected %0d, got %0d", want.gram_re, got.gram_re);
        errors++;
      end
      if (got.gram_im !== want.gram_im) begin
        $error("gram_im: expected %0d, got %0d", want.gram_im, got.gram_im);
        errors++;
      end
      if (got.final_entry !== want.final_entry) begin
        $error("final_entry: expected %0d, got %0d", want.final_entry, got.final_entry);
        errors++;
      end
    endfunction
  endclass

endpackage

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// Top-level testbench for regularized_gram_matrix: directed and random channel rows,
// noise_variance sweeps, bursty sender, stalling receiver. Depends on rgm_pkg, rgm_if,
// gram_check_pkg and the RTL.
module testbench;
  import rgm_pkg::*;
  import gram_check_pkg::*;

  localparam int unsigned QuietLimit   = 4000;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned RandomRows   = 72;
  localparam samp_t       SampMin      = 16'sh8000;
  localparam samp_t       SampMax      = 16'sh7FFF;

  typedef enum int {MatZero, MatMinAll, MatMaxAll, MatCrossMax, MatDiagOnly, MatRandom}
    mat_kind_e;
  typedef enum int {RdyAlways, RdyRandom, RdyPattern, RdySparse} rdy_mode_e;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [NoiseW-1:0] cfg_wdata_i;

  rgm_in_if  in_if();
  rgm_out_if res_if();

  regularized_gram_matrix dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .res_o       (res_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  gram_scoreboard sb = new();

  bit          hold_off_req = 1'b0;
  bit          steady       = 1'b0;
  int unsigned burst_left   = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic samp_t rand_samp();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 6) begin
      return samp_t'($urandom);
    end
    if (pick < 8) begin
      return ($urandom_range(1) != 0) ? SampMin : SampMax;
    end
    return samp_t'(int'($urandom_range(64)) - 32);
  endfunction

  function automatic h_row_t build_row(mat_kind_e kind, int k);
    h_row_t r;
    for (int c = 0; c < NumCols; c++) begin
      case (kind)
        MatZero: begin
          r.re[c] = '0;
          r.im[c] = '0;
        end
        MatMinAll: begin
          r.re[c] = SampMin;
          r.im[c] = SampMin;
        end
        MatMaxAll: begin
          r.re[c] = SampMax;
          r.im[c] = SampMax;
        end
        MatCrossMax: begin
          r.re[c] = SampMin;
          r.im[c] = (c % 2 != 0) ? SampMax : SampMin;
        end
        MatDiagOnly: begin
          r.re[c] = (c == k) ? samp_t'(16'sh4000) : samp_t'(0);
          r.im[c] = (c == k) ? samp_t'(16'shC000) : samp_t'(0);
        end
        default: begin
          r.re[c] = rand_samp();
          r.im[c] = rand_samp();
        end
      endcase
    end
    return r;
  endfunction

  task automatic drive_payload(h_row_t r);
    in_if.h0_re <= r.re[0];
    in_if.h0_im <= r.im[0];
    in_if.h1_re <= r.re[1];
    in_if.h1_im <= r.im[1];
    in_if.h2_re <= r.re[2];
    in_if.h2_im <= r.im[2];
    in_if.h3_re <= r.re[3];
    in_if.h3_im <= r.im[3];
  endtask

  task automatic write_noise(logic [NoiseW-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_noise(v);
  endtask

  // offer one row request; gaps fall between bursts
  // ready is sampled mid-cycle, where it holds the value seen at the next edge
  task automatic push_row(h_row_t r);
    int unsigned gap;
    bit          taken;
    if (burst_left == 0) begin
      gap = steady ? 0 : $urandom_range(6);
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(40, 20) : $urandom_range(8, 1);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
    in_if.valid <= 1'b1;
    drive_payload(r);
    do begin
      @(negedge clk_i);
      taken = (in_if.ready === 1'b1);
      @(posedge clk_i);
    end while (!taken);
    sb.note_row(r);
  endtask

  task automatic send_matrix(mat_kind_e kind);
    for (int k = 0; k < RowCount; k++) begin
      push_row(build_row(kind, k));
    end
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin : receiver
    rdy_mode_e   mode;
    int unsigned mode_left;
    int unsigned period;
    int unsigned tick;
    mode      = RdyAlways;
    mode_left = 0;
    period    = 3;
    tick      = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        res_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        if (mode_left == 0) begin
          mode      = rdy_mode_e'($urandom_range(3));
          mode_left = $urandom_range(80, 10);
          period    = $urandom_range(5, 2);
        end else begin
          mode_left--;
        end
        tick++;
        case (mode)
          RdyAlways:  res_if.ready <= 1'b1;
          RdyRandom:  res_if.ready <= ($urandom_range(3) != 0);
          RdyPattern: res_if.ready <= (tick % period != 0);
          default:    res_if.ready <= ($urandom_range(3) == 0);
        endcase
      end
    end
  end

  // handshake signals are stable from mid-cycle up to the accepting edge
  always @(negedge clk_i) begin : entry_monitor
    gram_entry_t got;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got.entry_row   = res_if.entry_row;
      got.entry_col   = res_if.entry_col;
      got.gram_re     = res_if.gram_re;
      got.gram_im     = res_if.gram_im;
      got.final_entry = res_if.final_entry;
      sb.check_entry(got);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(negedge clk_i);
      if ((in_if.valid && in_if.ready) || (res_if.valid && res_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("regularized_gram_matrix regression: fail");
    $finish;
  end

  initial begin : stimulus
    h_row_t            zero_row;
    int unsigned       phase;
    int unsigned       random_rows;
    int unsigned       n_mat;
    logic [NoiseW-1:0] nv;
    phase       = 0;
    random_rows = 0;
    zero_row    = build_row(MatZero, 0);
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    in_if.valid <= 1'b0;
    drive_payload(zero_row);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_noise('0);
    send_matrix(MatZero);
    send_matrix(MatMinAll);
    send_matrix(MatMaxAll);
    send_matrix(MatCrossMax);
    send_matrix(MatDiagOnly);
    drain();
    write_noise('1);
    send_matrix(MatMinAll);
    send_matrix(MatCrossMax);
    drain();

    while (random_rows < RandomRows) begin
      case (phase % 4)
        0:       nv = $urandom;
        1:       nv = '1;
        2:       nv = '0;
        default: nv = NoiseW'(1);
      endcase
      write_noise(nv);
      // one phase keeps the sender busy while the receiver holds off
      if (phase == 1) begin
        steady       = 1'b1;
        hold_off_req = 1'b1;
        n_mat        = 6;
      end else begin
        n_mat = $urandom_range(6, 2);
      end
      repeat (n_mat) send_matrix(MatRandom);
      random_rows += n_mat * RowCount;
      steady = 1'b0;
      drain();
      phase++;
    end

    $display("%0d rows in, %0d Gram entries checked over %0d matrices and %0d noise phases",
             sb.rows_noted, sb.entries_checked, sb.entries_checked / NumEntries, phase + 2);
    $display("covered full-scale rows, cross terms, sparse diagonals and a long output stall");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("regularized_gram_matrix regression: pass");
    end else begin
      $display("regularized_gram_matrix regression: fail");
    end
    $finish;
  end

endmodule

// ===== regularized_gram_matrix.f =====
rtl/rgm_pkg.sv
rtl/rgm_if.sv
rtl/rgm_mult.sv
rtl/rgm_accum.sv
rtl/rgm_emit.sv
rtl/regularized_gram_matrix.sv
rtl/rgm_checker.sv
test/gram_check_pkg.sv
test/testbench.sv
